// ===== src/bba_pkg.sv =====
// Package for the block bitmap allocator.
// Holds the word types, opcodes, register indexes and reset values.
// Used by every file under src; depends on nothing else.
package bba_pkg;

	// Free map is kept in rows of this many bits.
	localparam int ROW_W    = 16;
	localparam int ROW_BITS = 4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_FORMAT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_COUNT = 1'd1;

	localparam logic [4:0]  BLOCK_SHIFT_RESET = 5'd12;
	localparam logic [10:0] RESERVED_RESET    = 11'd14;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [18:0] byte_count;
		logic [9:0]  block_index;
	} cmd_word_t;

	typedef struct packed {
		logic [9:0] granted_block;
		logic       granted_valid;
		logic       last_of_run;
		logic       short_grant;
	} result_word_t;

	typedef struct packed {
		logic                found;
		logic [ROW_BITS-1:0] pos;
	} pick_t;

endpackage

// ===== src/bba_map_ram.sv =====
// Free-map row memory of the block bitmap allocator.
// One write port and one read port with registered read data; uses bba_pkg.
module bba_map_ram #(
	parameter int ROWS = 64,
	parameter int AW   = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [bba_pkg::ROW_W-1:0] wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [bba_pkg::ROW_W-1:0] rdata
);

	logic [bba_pkg::ROW_W-1:0] mem [ROWS];
	logic [bba_pkg::ROW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bba_pick.sv =====
// Lowest-set-bit finder shared by the allocation scan.
// Reports whether a row word has a free block and where the lowest one is; uses bba_pkg.
module bba_pick (
	input  logic [bba_pkg::ROW_W-1:0] word,
	output bba_pkg::pick_t            pick
);

	always_comb begin
		pick.found = |word;
		pick.pos   = '0;
		// Walking downwards leaves the lowest set bit as the final answer.
		for (int b = bba_pkg::ROW_W - 1; b >= 0; b--) begin
			if (word[b]) begin
				pick.pos = bba_pkg::ROW_BITS'(b);
			end
		end
	end

endmodule

// ===== src/block_bitmap_allocator.sv =====
// First-fit block allocator over a one-bit-per-block free map held in a memory of
// 16-bit rows. A command is taken when start is high and busy is low; results come out
// on result with result_strobe high for one cycle each and cannot be held off. Free
// reads the row and writes it back with the bit set. Format rewrites one row a cycle
// over ROWS = ceil(NUM_BLOCKS / 16) rows, as does the clearing pass after reset.
// Allocate first works out the block count and ends there for a zero-byte request;
// otherwise each row is loaded, scanned and written back while the next is read on the
// read port, and the shared bit finder claims one block per cycle. Configuration
// writes are always taken; the block shift applies from the next allocate and the
// reserved count from the next format.
module block_bitmap_allocator #(
	parameter int NUM_BLOCKS = 1024,
	parameter int MAX_GRANT  = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  bba_pkg::cmd_word_t                 cmd,
	output logic                               result_strobe,
	output bba_pkg::result_word_t              result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ROWS = (NUM_BLOCKS + bba_pkg::ROW_W - 1) / bba_pkg::ROW_W;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BNW  = RAW + bba_pkg::ROW_BITS;
	localparam int LW   = $clog2(NUM_BLOCKS + 1);
	localparam int CW   = $clog2(MAX_GRANT + 1);
	localparam int REM  = NUM_BLOCKS % bba_pkg::ROW_W;
	localparam logic [bba_pkg::ROW_W-1:0] LAST_MASK =
		(REM == 0) ? '1 : bba_pkg::ROW_W'((32'd1 << REM) - 32'd1);
	localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

	typedef enum logic [8:0] {
		ST_CLEAR   = 9'b000000001,
		ST_IDLE    = 9'b000000010,
		ST_CALC    = 9'b000000100,
		ST_LOAD    = 9'b000001000,
		ST_SCAN    = 9'b000010000,
		ST_WB      = 9'b000100000,
		ST_FINISH  = 9'b001000000,
		ST_FREE_RD = 9'b010000000,
		ST_FREE_WR = 9'b100000000
	} state_t;

	state_t state_q;

	logic [4:0]  block_shift_q;
	logic [10:0] reserved_q;
	logic [LW-1:0]  lim_q;
	logic [RAW-1:0] row_q;
	logic [CW-1:0]  count_q;
	logic           pend_v_q;
	logic           strobe_q;

	logic [18:0] bytes_q;
	logic [18:0] need_q;
	logic [CW-1:0] want_q;
	logic [bba_pkg::ROW_W-1:0] row_word_q;
	logic [BNW-1:0] pend_blk_q;
	logic [bba_pkg::ROW_BITS-1:0] bit_q;
	bba_pkg::result_word_t res_q;

	logic accept;
	logic [18:0] need;
	logic [18:0] quot;
	logic [18:0] low_bits;
	logic [CW-1:0] want;
	logic [LW-1:0] lim_new;
	logic idx_ok;
	logic claim;
	logic [BNW-1:0] new_blk;
	logic [31:0] pend_ext;
	logic [bba_pkg::ROW_W-1:0] fmt_word;

	logic ram_we;
	logic ram_re;
	logic [RAW-1:0] ram_waddr;
	logic [RAW-1:0] ram_raddr;
	logic [bba_pkg::ROW_W-1:0] ram_wdata;
	logic [bba_pkg::ROW_W-1:0] ram_rdata;

	bba_pkg::pick_t pick;

	bba_map_ram #(
		.ROWS (ROWS),
		.AW   (RAW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bba_pick u_pick (
		.word (row_word_q),
		.pick (pick)
	);

	assign busy          = (state_q != ST_IDLE);
	assign accept        = start && !busy;
	assign cfg_ready     = 1'b1;
	assign result_strobe = strobe_q;
	assign result        = res_q;

	// Rounding up: whole blocks plus one more if any remainder bits are set.
	assign quot     = bytes_q >> block_shift_q;
	assign low_bits = bytes_q & ~(19'h7FFFF << block_shift_q);
	assign need     = quot + 19'(|low_bits);
	assign want     = (need > 19'(MAX_GRANT)) ? CW'(MAX_GRANT) : CW'(need);

	assign lim_new = (32'(reserved_q) > NUM_BLOCKS) ? LW'(NUM_BLOCKS) : LW'(reserved_q);
	assign idx_ok  = (32'(cmd.block_index) < NUM_BLOCKS);
	assign claim   = pick.found && (count_q < want_q);
	assign new_blk = {row_q, pick.pos};
	assign pend_ext = 32'(pend_blk_q);

	// Row contents after a format: reserved rows cleared, the boundary row split.
	always_comb begin
		if (32'(row_q) < 32'(lim_q >> bba_pkg::ROW_BITS)) begin
			fmt_word = '0;
		end else if (32'(row_q) == 32'(lim_q >> bba_pkg::ROW_BITS)) begin
			fmt_word = '1 << lim_q[bba_pkg::ROW_BITS-1:0];
		end else begin
			fmt_word = '1;
		end
		if (row_q == LAST_ROW) begin
			fmt_word = fmt_word & LAST_MASK;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = row_q;
		ram_raddr = row_q;
		ram_wdata = row_word_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = fmt_word;
			end
			ST_CALC: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ST_WB: begin
				ram_we    = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = row_q + RAW'(1);
			end
			ST_FREE_RD: begin
				ram_re = 1'b1;
			end
			ST_FREE_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata | (bba_pkg::ROW_W'(1) << bit_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			block_shift_q <= bba_pkg::BLOCK_SHIFT_RESET;
			reserved_q    <= bba_pkg::RESERVED_RESET;
			lim_q         <= (32'(bba_pkg::RESERVED_RESET) > NUM_BLOCKS) ?
				LW'(NUM_BLOCKS) : LW'(bba_pkg::RESERVED_RESET);
			row_q         <= '0;
			count_q       <= '0;
			pend_v_q      <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					bba_pkg::REG_BLOCK_SHIFT:    block_shift_q <= cfg_data[4:0];
					bba_pkg::REG_RESERVED_COUNT: reserved_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (row_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end else begin
						row_q <= row_q + RAW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.opcode)
							bba_pkg::OP_ALLOC: state_q <= ST_CALC;
							bba_pkg::OP_FREE: begin
								if (idx_ok) begin
									row_q   <= RAW'(cmd.block_index >> bba_pkg::ROW_BITS);
									state_q <= ST_FREE_RD;
								end
							end
							bba_pkg::OP_FORMAT: begin
								lim_q   <= lim_new;
								row_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CALC: begin
					count_q  <= '0;
					pend_v_q <= 1'b0;
					row_q    <= '0;
					if (need == '0) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (claim) begin
						count_q  <= count_q + CW'(1);
						pend_v_q <= 1'b1;
						strobe_q <= pend_v_q;
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (count_q == want_q || row_q == LAST_ROW) begin
						state_q <= ST_FINISH;
					end else begin
						row_q   <= row_q + RAW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_FINISH: begin
					strobe_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_FREE_RD: state_q <= ST_FREE_WR;
				ST_FREE_WR: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			bytes_q <= cmd.byte_count;
			bit_q   <= cmd.block_index[bba_pkg::ROW_BITS-1:0];
		end
		if (state_q == ST_CALC) begin
			need_q <= need;
			want_q <= want;
			res_q  <= '{granted_block: '0, granted_valid: 1'b0,
				last_of_run: 1'b1, short_grant: 1'b0};
		end
		if (state_q == ST_LOAD) begin
			row_word_q <= ram_rdata;
		end
		if (state_q == ST_SCAN && claim) begin
			row_word_q[pick.pos] <= 1'b0;
			pend_blk_q           <= new_blk;
			// The previous claim is only sent once another claim proves it is not the last.
			res_q <= '{granted_block: pend_ext[9:0], granted_valid: 1'b1,
				last_of_run: 1'b0, short_grant: 1'b0};
		end
		if (state_q == ST_FINISH) begin
			if (pend_v_q) begin
				res_q <= '{granted_block: pend_ext[9:0], granted_valid: 1'b1,
					last_of_run: 1'b1, short_grant: (19'(count_q) < need_q)};
			end else begin
				res_q <= '{granted_block: '0, granted_valid: 1'b0,
					last_of_run: 1'b1, short_grant: 1'b1};
			end
		end
	end

endmodule

// ===== verif/bba_grant_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the block bitmap allocator: holds its own free map and register copies,
// predicts the result words of every accepted command and checks them in order.
// Depends on bba_pkg for the word types, opcodes, register indexes and reset values.
module bba_grant_checker #(
	parameter int NUM_BLOCKS = 1024,
	parameter int MAX_GRANT  = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  bba_pkg::cmd_word_t                 cmd,
	input  logic                               result_strobe,
	input  bba_pkg::result_word_t              result,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 errors,
	output int                                 outstanding
);
	import bba_pkg::*;

	logic [NUM_BLOCKS-1:0] free_bits;
	logic [4:0]            shift_cfg;
	logic [10:0]           reserve_cfg;
	result_word_t          grant_queue[$];
	result_word_t          head_word;
	int                    mismatches;

	task automatic reformat_map();
		int lim;
		lim = (reserve_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(reserve_cfg);
		for (int i = 0; i < NUM_BLOCKS; i++)
			free_bits[i] = (i >= lim);
	endtask

	task automatic expect_word(input result_word_t w);
		grant_queue = {grant_queue, w};
	endtask

	task automatic predict_command(input cmd_word_t c);
		longint unsigned span_m1;
		longint unsigned need;
		longint unsigned want;
		int              claimed;
		result_word_t    word;
		case (c.opcode)
		OP_FREE: begin
			if (c.block_index < NUM_BLOCKS)
				free_bits[c.block_index] = 1'b1;
		end
		OP_FORMAT: begin
			reformat_map();
		end
		OP_ALLOC: begin
			span_m1 = (64'd1 << shift_cfg) - 64'd1;
			need    = (64'(c.byte_count) + span_m1) >> shift_cfg;
			want    = (need > MAX_GRANT) ? MAX_GRANT : need;
			claimed = 0;
			word    = '0;
			if (need == 0) begin
				word.last_of_run = 1'b1;
				expect_word(word);
			end else begin
				// Each claimed block is held back one step so the final one can be marked.
				for (int i = 0; i < NUM_BLOCKS && claimed < want; i++) begin
					if (free_bits[i]) begin
						free_bits[i] = 1'b0;
						if (claimed > 0)
							expect_word(word);
						word = '{granted_block: 10'(i), granted_valid: 1'b1,
							last_of_run: 1'b0, short_grant: 1'b0};
						claimed++;
					end
				end
				word.last_of_run = 1'b1;
				word.short_grant = (claimed < need);
				expect_word(word);
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cfg   = BLOCK_SHIFT_RESET;
			reserve_cfg = RESERVED_RESET;
			reformat_map();
			grant_queue.delete();
			mismatches  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BLOCK_SHIFT)
					shift_cfg = cfg_data[4:0];
				else if (cfg_index == REG_RESERVED_COUNT)
					reserve_cfg = cfg_data;
			end
			// Results are checked before a new command is predicted, so a stray word
			// can never be matched against expectations of the command taken alongside it.
			if (result_strobe) begin
				if (grant_queue.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word: block %0d valid %b last %b short %b",
						$time, result.granted_block, result.granted_valid,
						result.last_of_run, result.short_grant);
				end else begin
					head_word = grant_queue.pop_front();
					if (result !== head_word) begin
						mismatches++;
						$display({"%0t: result mismatch: expected block %0d valid %b last %b ",
							"short %b, got block %0d valid %b last %b short %b"}, $time,
							head_word.granted_block, head_word.granted_valid,
							head_word.last_of_run, head_word.short_grant,
							result.granted_block, result.granted_valid,
							result.last_of_run, result.short_grant);
					end
				end
			end
			if (start && !busy)
				predict_command(cmd);
		end
		errors      <= mismatches;
		outstanding <= grant_queue.size();
	end

endmodule

// ===== verif/tb_block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the block bitmap allocator testbench: clock, reset, command and
// register stimulus, watchdog and verdict. Uses bba_pkg, the DUT and the checker.
module tb_block_bitmap_allocator;
	import bba_pkg::*;

	localparam int NUM_BLOCKS     = 1024;
	localparam int MAX_GRANT      = 64;
	localparam int SETTLE_CYCLES  = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 73;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	cmd_word_t             cmd = '0;
	logic                  result_strobe;
	result_word_t          result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors;
	int                    outstanding;

	logic [4:0] cur_shift = BLOCK_SHIFT_RESET;
	bit         steady_feed = 1'b0;

	int phase_shift[PHASES]   = '{12, 6, 16, 9, 6, 16};
	int phase_reserve[PHASES] = '{14, 0, 1024, 700, 2047, 3};
	bit phase_wide[PHASES]    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	bit phase_format[PHASES]  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

	block_bitmap_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.MAX_GRANT (MAX_GRANT)
	) u_dut (.*);

	bba_grant_checker #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.MAX_GRANT (MAX_GRANT)
	) u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic cmd_word_t make_cmd(input logic [1:0] op, input logic [18:0] bytes,
		input logic [9:0] idx);
		cmd_word_t c;
		c.opcode      = op;
		c.byte_count  = bytes;
		c.block_index = idx;
		return c;
	endfunction

	// Mostly allocations sized in whole blocks of the current shift, with frees aimed
	// at the low blocks where first fit lands; the unused fields carry random bits.
	function automatic cmd_word_t random_cmd(input bit wide);
		cmd_word_t       c;
		int              pick;
		int              blocks;
		longint unsigned span;
		longint unsigned bytes;
		c.opcode      = OP_ALLOC;
		c.byte_count  = 19'($urandom);
		c.block_index = 10'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			if (wide)
				blocks = $urandom_range(16, 80);
			else if ($urandom_range(0, 9) < 7)
				blocks = $urandom_range(1, 4);
			else
				blocks = $urandom_range(5, 70);
			span  = 64'd1 << cur_shift;
			bytes = longint'(blocks - 1) * span + $urandom_range(1, 32'(span));
			if (bytes > 64'h7FFFF)
				bytes = $urandom_range(1, 32'h7FFFF);
			c.byte_count = 19'(bytes);
		end else if (pick < 90) begin
			c.opcode = OP_FREE;
			if ($urandom_range(0, 1) == 0)
				c.block_index = 10'($urandom_range(0, 127));
		end else if (pick < 93) begin
			c.opcode = OP_FORMAT;
		end else if (pick < 95) begin
			c.opcode = OP_UNUSED;
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_word_t c);
		int gap;
		gap = steady_feed ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// A format or free gives no word back, so the block may still be working after the
	// last expected word; the pause covers the longest such command.
	task automatic reconfigure(input logic [4:0] shift, input logic [10:0] reserve);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_BLOCK_SHIFT, {6'($urandom), shift});
		write_reg(REG_RESERVED_COUNT, reserve);
		cfg_valid <= 1'b0;
		cur_shift = shift;
	endtask

	task automatic run_random(input int count, input bit wide);
		for (int n = 0; n < count; n++) begin
			if (n % 24 == 0)
				steady_feed = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 39) == 0)
				wait_drained();
			send_cmd(random_cmd(wide));
		end
		steady_feed = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: 4 KiB blocks, lowest 14 blocks reserved.
		send_cmd(make_cmd(OP_ALLOC, 19'd0, 10'h3FF));
		send_cmd(make_cmd(OP_ALLOC, 19'd1, 10'd0));
		send_cmd(make_cmd(OP_ALLOC, 19'd4097, 10'd0));
		send_cmd(make_cmd(OP_ALLOC, 19'h7FFFF, 10'h3FF));
		send_cmd(make_cmd(OP_FREE, 19'h7FFFF, 10'd0));
		send_cmd(make_cmd(OP_FREE, 19'd0, 10'h3FF));
		send_cmd(make_cmd(OP_FREE, 19'd0, 10'd16));
		send_cmd(make_cmd(OP_ALLOC, 19'd8192, 10'd0));
		send_cmd(make_cmd(OP_UNUSED, 19'h7FFFF, 10'h3FF));
		send_cmd(make_cmd(OP_ALLOC, 19'd262144, 10'd0));
		send_cmd(make_cmd(OP_FORMAT, 19'd0, 10'd0));
		send_cmd(make_cmd(OP_ALLOC, 19'd1, 10'd0));

		// Reserved count beyond the map saturates, leaving nothing free.
		reconfigure(5'd0, 11'd2047);
		send_cmd(make_cmd(OP_FORMAT, 19'd0, 10'd0));
		send_cmd(make_cmd(OP_ALLOC, 19'd1, 10'd0));
		send_cmd(make_cmd(OP_FREE, 19'd0, 10'h3FF));
		send_cmd(make_cmd(OP_FREE, 19'd0, 10'd512));
		send_cmd(make_cmd(OP_ALLOC, 19'd5, 10'd0));
		send_cmd(make_cmd(OP_ALLOC, 19'd0, 10'd0));
		send_cmd(make_cmd(OP_FREE, 19'd0, 10'd7));
		send_cmd(make_cmd(OP_ALLOC, 19'd1, 10'd0));

		// Widest shift: any nonzero request is a single block.
		reconfigure(5'd31, 11'd0);
		send_cmd(make_cmd(OP_FORMAT, 19'd0, 10'd0));
		send_cmd(make_cmd(OP_ALLOC, 19'h7FFFF, 10'd0));
		send_cmd(make_cmd(OP_ALLOC, 19'd1, 10'd0));

		for (int p = 0; p < PHASES; p++) begin
			reconfigure(5'(phase_shift[p]), 11'(phase_reserve[p]));
			if (phase_format[p])
				send_cmd(make_cmd(OP_FORMAT, 19'($urandom), 10'($urandom)));
			run_random(PHASE_ITEMS, phase_wide[p]);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("** block_bitmap_allocator: PASSED **");
		else
			$display("** block_bitmap_allocator: FAILED **");
		$finish;
	end

	// Ends the run if no word moves on any channel for too long.
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("** block_bitmap_allocator: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
src/bba_pkg.sv
src/bba_map_ram.sv
src/bba_pick.sv
src/block_bitmap_allocator.sv
verif/bba_grant_checker.sv
verif/tb_block_bitmap_allocator.sv
